// File: rtl/sbus_frame_encoder_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the servo frame encoder
// Shared shorthand for the concurrent checks; clk and rst_n must be in scope.
// ----------------------------------------------------------------------------
`ifndef SBUS_FRAME_ENCODER_UNIT_MACROS_SVH
`define SBUS_FRAME_ENCODER_UNIT_MACROS_SVH

// Check a consequent in the same cycle as the antecedent
`define SBFE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after the antecedent
`define SBFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sbfe_pkg.sv
// ----------------------------------------------------------------------------
// sbfe_pkg
// Types and constants shared by the servo frame encoder modules.
// ----------------------------------------------------------------------------
package sbfe_pkg;

  localparam int VALUE_W = 13;
  localparam int BYTE_W  = 8;
  localparam int FIELD_W = 11;
  localparam int ACC_W   = 18;
  localparam int PEND_W  = 3;
  localparam int POS_W   = 5;
  localparam int QUOT_W  = 12;
  localparam int MAG_W   = 16;

  localparam logic [BYTE_W-1:0]  HDR_BYTE    = 8'h0F;
  localparam logic [BYTE_W-1:0]  END_BYTE    = 8'h00;
  localparam logic [FIELD_W-1:0] CHAN_CENTER = 11'd992;
  localparam logic [FIELD_W-1:0] CHAN_MAX    = 11'd2047;
  localparam logic [4:0]         CHAN_BITS   = 5'd11;
  localparam logic [POS_W-1:0]   DATA_CHANS  = 5'd16;
  localparam int                 FLAG_AUX17  = 0;
  localparam int                 FLAG_AUX18  = 1;

  // Reciprocal of ten: x / 10 == (x * RECIP_TEN) >> 19 for x below 81920
  localparam logic [MAG_W-1:0]   RECIP_TEN   = 16'd52429;
  localparam int                 RECIP_SHIFT = 19;

  // Item classes by frame position
  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_FLAG,
    KIND_FINAL
  } item_kind_t;

  // One run of output bytes caused by a single item
  typedef struct packed {
    logic [BYTE_W-1:0] byte0;
    logic [BYTE_W-1:0] byte1;
    logic [BYTE_W-1:0] byte2;
    logic [1:0]        count;
    logic              eof;
  } run_t;

endpackage

// File: rtl/sbfe_in_if.sv
// ----------------------------------------------------------------------------
// sbfe_in_if
// Request channel carrying one centred channel value per item.
// ----------------------------------------------------------------------------
interface sbfe_in_if import sbfe_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] channel_value;

  modport source (output valid, output channel_value, input ready);
  modport sink   (input valid, input channel_value, output ready);
endinterface

// File: rtl/sbfe_out_if.sv
// ----------------------------------------------------------------------------
// sbfe_out_if
// Request channel carrying one frame byte per item.
// ----------------------------------------------------------------------------
interface sbfe_out_if import sbfe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic              last_of_run;
  logic              end_of_frame;

  modport source (output valid, output frame_byte, output last_of_run,
                  output end_of_frame, input ready);
  modport sink   (input valid, input frame_byte, input last_of_run,
                  input end_of_frame, output ready);
endinterface

// File: rtl/sbfe_front.sv
// ----------------------------------------------------------------------------
// sbfe_front
// Accept channel values, scale and clamp them, pack bits and push byte runs.
// ----------------------------------------------------------------------------
module sbfe_front import sbfe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  sbfe_in_if.sink    in_ch,
  output logic       push,
  output run_t       push_run,
  input  logic       q_full
);

  // Stage A registers: reciprocal quotient and sign information
  logic              a_valid_r, a_valid_nxt;
  logic [QUOT_W-1:0] a_quot_r;
  logic              a_neg_r;
  logic              a_posv_r;

  // Stage B state: frame position and bit packing
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic              aux_r, aux_nxt;

  logic                b_go;
  logic                a_load;
  logic signed [15:0]  prod8;
  logic [MAG_W-1:0]    mag;
  logic [2*MAG_W-1:0]  prod;
  item_kind_t          kind;
  logic [12:0]         sum_up;
  logic [FIELD_W-1:0]  field;
  logic [ACC_W-1:0]    acc_base;
  logic [PEND_W-1:0]   pend_base;
  logic [ACC_W-1:0]    merged;
  logic [4:0]          cnt;
  logic                two;
  logic [4:0]          pend_left;

  // Advance stage B when the queue has room; stage A refills behind it
  assign b_go        = a_valid_r && !q_full;
  assign in_ch.ready = !a_valid_r || b_go;
  assign a_load      = in_ch.valid && in_ch.ready;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (a_load) begin
      a_valid_nxt = 1'b1;
    end else if (b_go) begin
      a_valid_nxt = 1'b0;
    end
  end

  // Magnitude of value*8, then divide by ten through the reciprocal
  assign prod8 = {in_ch.channel_value, 3'b000};
  assign mag   = prod8[15] ? MAG_W'(-prod8) : MAG_W'(prod8);
  assign prod  = {{MAG_W{1'b0}}, mag} * {{MAG_W{1'b0}}, RECIP_TEN};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_quot_r <= prod[RECIP_SHIFT +: QUOT_W];
      a_neg_r  <= in_ch.channel_value[VALUE_W-1];
      a_posv_r <= !in_ch.channel_value[VALUE_W-1] && (in_ch.channel_value != '0);
    end
  end

  // Classify by frame position
  always_comb begin
    if (pos_r < DATA_CHANS) begin
      kind = KIND_DATA;
    end else if (pos_r == DATA_CHANS) begin
      kind = KIND_FLAG;
    end else begin
      kind = KIND_FINAL;
    end
  end

  // Offset and clamp the scaled value to the 11-bit field
  assign sum_up = {2'b00, CHAN_CENTER} + {1'b0, a_quot_r};
  always_comb begin
    if (a_neg_r) begin
      field = ({1'b0, a_quot_r} >= {2'b00, CHAN_CENTER}) ? '0
            : FIELD_W'({2'b00, CHAN_CENTER} - {1'b0, a_quot_r});
    end else begin
      field = (sum_up > {2'b00, CHAN_MAX}) ? CHAN_MAX : sum_up[FIELD_W-1:0];
    end
  end

  // Merge the field above the pending bits; frame start clears them
  assign acc_base  = (pos_r == '0) ? '0 : acc_r;
  assign pend_base = (pos_r == '0) ? '0 : pend_r;
  assign merged    = acc_base | ({{(ACC_W-FIELD_W){1'b0}}, field} << pend_base);
  assign cnt       = {2'b00, pend_base} + CHAN_BITS;
  assign two       = cnt >= 5'd16;
  assign pend_left = two ? (cnt - 5'd16) : (cnt - 5'd8);

  // Build the run and the next packing state
  always_comb begin
    pos_nxt  = pos_r;
    acc_nxt  = acc_r;
    pend_nxt = pend_r;
    aux_nxt  = aux_r;
    push     = 1'b0;
    push_run = '0;
    unique case (kind)
      KIND_DATA: begin
        push = b_go;
        if (pos_r == '0) begin
          push_run.byte0 = HDR_BYTE;
          push_run.byte1 = merged[7:0];
          push_run.byte2 = merged[15:8];
          push_run.count = two ? 2'd3 : 2'd2;
        end else begin
          push_run.byte0 = merged[7:0];
          push_run.byte1 = merged[15:8];
          push_run.count = two ? 2'd2 : 2'd1;
        end
        acc_nxt  = two ? (merged >> 16) : (merged >> 8);
        pend_nxt = pend_left[PEND_W-1:0];
        pos_nxt  = pos_r + 1'b1;
      end
      KIND_FLAG: begin
        aux_nxt = a_posv_r;
        pos_nxt = pos_r + 1'b1;
      end
      KIND_FINAL: begin
        push                       = b_go;
        push_run.byte0             = '0;
        push_run.byte0[FLAG_AUX17] = aux_r;
        push_run.byte0[FLAG_AUX18] = a_posv_r;
        push_run.byte1             = END_BYTE;
        push_run.count             = 2'd2;
        push_run.eof               = 1'b1;
        pos_nxt                    = '0;
        aux_nxt                    = 1'b0;
        acc_nxt                    = '0;
        pend_nxt                   = '0;
      end
      default: begin
        pos_nxt = '0;
      end
    endcase
  end

  // Commit packing state when stage B advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      acc_r  <= '0;
      pend_r <= '0;
      aux_r  <= 1'b0;
    end else if (b_go) begin
      pos_r  <= pos_nxt;
      acc_r  <= acc_nxt;
      pend_r <= pend_nxt;
      aux_r  <= aux_nxt;
    end
  end

endmodule

// File: rtl/sbfe_queue.sv
// ----------------------------------------------------------------------------
// sbfe_queue
// Small FIFO of byte runs between the packing front and the byte back end.
// ----------------------------------------------------------------------------
module sbfe_queue import sbfe_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  run_t push_run,
  output logic full,
  input  logic pop,
  output logic empty,
  output run_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  run_t             slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = count_r == FULL_CNT;
  assign empty = count_r == '0;
  assign head  = slots_r[rd_ptr_r];

  // Advance pointers with explicit wrap
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed run
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_run;
    end
  end

endmodule

// File: rtl/sbfe_back.sv
// ----------------------------------------------------------------------------
// sbfe_back
// Hold one run in an output register; hand out one byte per cycle while ready.
// ----------------------------------------------------------------------------
module sbfe_back import sbfe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       empty,
  input  run_t       head,
  output logic       pop,
  sbfe_out_if.source out_ch
);

  logic       cur_valid_r, cur_valid_nxt;
  run_t       cur_r;
  logic [1:0] idx_r, idx_nxt;
  logic       last;
  logic       done;

  assign last = idx_r == (cur_r.count - 2'd1);
  assign done = cur_valid_r && out_ch.ready && last;
  assign pop  = (!cur_valid_r || done) && !empty;

  // Select the current byte of the run
  always_comb begin
    case (idx_r)
      2'd0:    out_ch.frame_byte = cur_r.byte0;
      2'd1:    out_ch.frame_byte = cur_r.byte1;
      default: out_ch.frame_byte = cur_r.byte2;
    endcase
  end

  assign out_ch.valid        = cur_valid_r;
  assign out_ch.last_of_run  = last;
  assign out_ch.end_of_frame = last && cur_r.eof;

  // Step through the run, reload from the queue at its end
  always_comb begin
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    if (pop) begin
      cur_valid_nxt = 1'b1;
      idx_nxt       = '0;
    end else if (done) begin
      cur_valid_nxt = 1'b0;
      idx_nxt       = '0;
    end else if (cur_valid_r && out_ch.ready) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head;
    end
  end

endmodule

// File: rtl/sbus_frame_encoder_unit.sv
// ----------------------------------------------------------------------------
// sbus_frame_encoder_unit
// Builds 25-byte serial servo frames from 18 centred channel values.
// ----------------------------------------------------------------------------
//   channel | dir | payload                               | per request
//   in_ch   | in  | channel_value[12:0] signed            | one channel value
//   out_ch  | out | frame_byte[7:0], last_of_run,         | one frame byte
//           |     | end_of_frame                          |
//
// The divide runs in the accepting cycle and is registered in stage A; packing
// follows, the run is written into the queue and the back end loads it into
// its output register. Bytes leave one per cycle while out_ch is ready.
// Reset (rst_n low, synchronous) returns to frame start and empties the queue.
// Input and output stall independently; the run queue absorbs up to
// QUEUE_DEPTH runs while the output is held.
// ----------------------------------------------------------------------------
module sbus_frame_encoder_unit import sbfe_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  sbfe_in_if.sink    in_ch,
  sbfe_out_if.source out_ch
);

  logic push;
  run_t push_run;
  logic q_full;
  logic q_empty;
  logic pop;
  run_t head;

  // Accept, scale and pack
  sbfe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .push     (push),
    .push_run (push_run),
    .q_full   (q_full)
  );

  // Decouple packing from byte delivery
  sbfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_run (push_run),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  // Deliver bytes
  sbfe_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (q_empty),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// File: rtl/sbfe_checker.sv
// ----------------------------------------------------------------------------
// sbfe_checker
// Port-level checks of the frame encoder output stream.
// ----------------------------------------------------------------------------
`include "sbus_frame_encoder_unit_macros.svh"

module sbfe_checker import sbfe_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] out_frame_byte,
  input logic              out_last_of_run,
  input logic              out_end_of_frame
);

  logic frame_start_r;

  // Track that the next delivered byte opens a new frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_start_r <= 1'b1;
    end else if (out_valid && out_ready) begin
      frame_start_r <= out_end_of_frame;
    end
  end

  `SBFE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_frame_byte), "output request changed while stalled")
  `SBFE_ASSERT_SAME(a_eof_last, out_valid && out_end_of_frame, out_last_of_run, "end of frame not last of run")
  `SBFE_ASSERT_SAME(a_eof_zero, out_valid && out_end_of_frame, out_frame_byte == END_BYTE, "closing byte not zero")
  `SBFE_ASSERT_SAME(a_header, out_valid && frame_start_r, out_frame_byte == HDR_BYTE && !out_last_of_run, "frame does not open with header")

endmodule

bind sbus_frame_encoder_unit sbfe_checker u_sbfe_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_frame_byte   (out_ch.frame_byte),
  .out_last_of_run  (out_ch.last_of_run),
  .out_end_of_frame (out_ch.end_of_frame)
);
